FILE: rtl/smpq_pkg.sv
// Shared types and defaults for the stable max priority queue.
// Used by smpq_ctrl, smpq_dp and stable_max_priority_queue; no dependencies.
package smpq_pkg;

  localparam int DEPTH_DEF    = 64;
  localparam int TAG_BITS_DEF = 16;

  localparam int SCORE_W = 32;
  localparam int TAG_W   = 16;
  localparam int OCC_W   = 7;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POP_WAIT,
    ST_INS_CMP,
    ST_INS_HEAD,
    ST_FINISH
  } state_t;

  // Read position relative to the head
  typedef enum logic [1:0] {
    RD_NONE,
    RD_HEAD,
    RD_LAST,
    RD_PREV
  } rd_sel_t;

  // Write source and position
  typedef enum logic [1:0] {
    WR_NONE,
    WR_NEW_HEAD,
    WR_NEW_NEXT,
    WR_OLD_NEXT
  } wr_sel_t;

  // Result kind
  typedef enum logic [1:0] {
    RES_NONE,
    RES_OK,
    RES_ERR,
    RES_POP
  } res_sel_t;

  typedef struct packed {
    logic     latch_req;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    logic     dec_j;
    logic     count_inc;
    logic     pop_adv;
    res_sel_t res_sel;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic is_pop;
    logic empty;
    logic full;
    logic j_zero;
    logic ge;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/smpq_ctrl.sv
// Controller state machine for the stable max priority queue.
// Depends on smpq_pkg; drives smpq_dp through cmd_t and reads stat_t.
module smpq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  smpq_pkg::stat_t stat,
  output smpq_pkg::cmd_t  cmd
);
  import smpq_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_nxt     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.is_pop) begin
          if (stat.empty) begin
            cmd.res_sel = RES_ERR;
            state_nxt   = ST_FINISH;
          end else begin
            cmd.rd_sel = RD_HEAD;
            state_nxt  = ST_POP_WAIT;
          end
        end else if (stat.full) begin
          cmd.res_sel = RES_ERR;
          state_nxt   = ST_FINISH;
        end else if (stat.empty) begin
          cmd.wr_sel    = WR_NEW_HEAD;
          cmd.count_inc = 1'b1;
          cmd.res_sel   = RES_OK;
          state_nxt     = ST_FINISH;
        end else begin
          cmd.rd_sel = RD_LAST;
          state_nxt  = ST_INS_CMP;
        end
      end
      ST_POP_WAIT: begin
        cmd.res_sel = RES_POP;
        cmd.pop_adv = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_INS_CMP: begin
        if (stat.ge) begin
          cmd.wr_sel    = WR_NEW_NEXT;
          cmd.count_inc = 1'b1;
          cmd.res_sel   = RES_OK;
          state_nxt     = ST_FINISH;
        end else begin
          // Shift the stored entry one place toward the tail
          cmd.wr_sel = WR_OLD_NEXT;
          if (stat.j_zero) begin
            state_nxt = ST_INS_HEAD;
          end else begin
            cmd.rd_sel = RD_PREV;
            cmd.dec_j  = 1'b1;
          end
        end
      end
      ST_INS_HEAD: begin
        cmd.wr_sel    = WR_NEW_HEAD;
        cmd.count_inc = 1'b1;
        cmd.res_sel   = RES_OK;
        state_nxt     = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/smpq_dp.sv
// Datapath for the stable max priority queue: circular entry memory, head,
// count, scan index, result and output registers. Depends on smpq_pkg.
module smpq_dp #(
  parameter int DEPTH    = smpq_pkg::DEPTH_DEF,
  parameter int TAG_BITS = smpq_pkg::TAG_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_req_type,
  input  logic [smpq_pkg::SCORE_W-1:0]       in_score,
  input  logic [smpq_pkg::TAG_W-1:0]         in_tag,
  input  smpq_pkg::cmd_t                     cmd,
  output smpq_pkg::stat_t                    stat,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [smpq_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [1:0]                         out_tuser
);
  import smpq_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ST_W   = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

  logic [SCORE_W-1:0] mem_score [DEPTH];
  logic [ST_W-1:0]    mem_tag   [DEPTH];

  logic               req_pop_r;
  logic [SCORE_W-1:0] new_score_r;
  logic [ST_W-1:0]    new_tag_r;
  logic [ADDR_W-1:0]  head_r;
  logic [CNT_W-1:0]   count_r;
  logic [ADDR_W-1:0]  j_r;
  logic [SCORE_W-1:0] rd_score_r;
  logic [ST_W-1:0]    rd_tag_r;
  logic               res_valid_r, res_err_r;
  logic [SCORE_W-1:0] res_score_r;
  logic [ST_W-1:0]    res_tag_r;
  logic               out_valid_r;
  logic               out_err_r;
  logic [SCORE_W-1:0] out_score_r;
  logic [ST_W-1:0]    out_tag_r;
  logic [OCC_W-1:0]   out_occ_r;

  logic [ADDR_W-1:0] rd_rel, wr_rel, rd_addr, wr_addr, j_last;
  logic [ADDR_W:0]   rd_sum, wr_sum, head_sum;
  logic              wr_en;
  logic [SCORE_W-1:0] wr_score;
  logic [ST_W-1:0]    wr_tag;

  assign j_last = ADDR_W'(count_r - CNT_W'(1));

  // Relative read position to physical address
  always_comb begin
    case (cmd.rd_sel)
      RD_LAST: rd_rel = j_last;
      RD_PREV: rd_rel = j_r - ADDR_W'(1);
      default: rd_rel = '0;
    endcase
    rd_sum  = {1'b0, head_r} + {1'b0, rd_rel};
    rd_addr = (rd_sum >= (ADDR_W+1)'(DEPTH)) ? ADDR_W'(rd_sum - (ADDR_W+1)'(DEPTH))
                                             : ADDR_W'(rd_sum);
  end

  // Write position and data
  always_comb begin
    wr_en    = 1'b1;
    wr_rel   = j_r + ADDR_W'(1);
    wr_score = new_score_r;
    wr_tag   = new_tag_r;
    case (cmd.wr_sel)
      WR_NEW_HEAD: wr_rel = '0;
      WR_NEW_NEXT: ;
      WR_OLD_NEXT: begin
        wr_score = rd_score_r;
        wr_tag   = rd_tag_r;
      end
      default: wr_en = 1'b0;
    endcase
    wr_sum  = {1'b0, head_r} + {1'b0, wr_rel};
    wr_addr = (wr_sum >= (ADDR_W+1)'(DEPTH)) ? ADDR_W'(wr_sum - (ADDR_W+1)'(DEPTH))
                                             : ADDR_W'(wr_sum);
    head_sum = {1'b0, head_r} + (ADDR_W+1)'(1);
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_score[wr_addr] <= wr_score;
      mem_tag[wr_addr]   <= wr_tag;
    end
    if (cmd.rd_sel != RD_NONE) begin
      rd_score_r <= mem_score[rd_addr];
      rd_tag_r   <= mem_tag[rd_addr];
    end
  end

  // Request latch, scan index and result payload
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_pop_r   <= in_req_type;
      new_score_r <= in_score;
      new_tag_r   <= ST_W'(in_tag);
    end
    if (cmd.rd_sel == RD_LAST) begin
      j_r <= j_last;
    end else if (cmd.dec_j) begin
      j_r <= j_r - ADDR_W'(1);
    end
    case (cmd.res_sel)
      RES_OK: begin
        res_valid_r <= 1'b0;
        res_err_r   <= 1'b0;
        res_score_r <= '0;
        res_tag_r   <= '0;
      end
      RES_ERR: begin
        res_valid_r <= 1'b0;
        res_err_r   <= 1'b1;
        res_score_r <= '0;
        res_tag_r   <= '0;
      end
      RES_POP: begin
        res_valid_r <= 1'b1;
        res_err_r   <= 1'b0;
        res_score_r <= rd_score_r;
        res_tag_r   <= rd_tag_r;
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      out_err_r   <= res_err_r;
      out_score_r <= res_score_r;
      out_tag_r   <= res_tag_r;
      out_occ_r   <= OCC_W'(count_r);
    end
  end

  // Head, count and output flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_tvalid  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.count_inc) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.pop_adv) begin
        count_r <= count_r - CNT_W'(1);
        head_r  <= (head_sum >= (ADDR_W+1)'(DEPTH)) ? '0 : ADDR_W'(head_sum);
      end
      if (cmd.load_out) begin
        out_tvalid  <= 1'b1;
        out_valid_r <= res_valid_r;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  assign stat.is_pop   = req_pop_r;
  assign stat.empty    = (count_r == '0);
  assign stat.full     = (count_r == CNT_W'(DEPTH));
  assign stat.j_zero   = (j_r == '0);
  assign stat.ge       = ($signed(rd_score_r) >= $signed(new_score_r));
  assign stat.out_free = !out_tvalid || out_tready;

  assign out_tdata = {1'b0, out_occ_r, TAG_W'(out_tag_r), out_score_r};
  assign out_tuser = {out_err_r, out_valid_r};

endmodule

FILE: rtl/stable_max_priority_queue.sv
// Stable max priority queue: top level joining smpq_ctrl and smpq_dp.
// Depends on smpq_pkg.
//
// Holds up to DEPTH entries (signed 32-bit score plus tag) in descending score
// order, equal scores in arrival order, in a circular memory with one write and
// one registered read port. Each request gives one result. Requests are handled
// one at a time. After it is accepted, a request passes through these states:
//   - a pop: decode, pop wait, finish;
//   - a refused request: decode, finish;
//   - an insert into an empty queue: decode, finish;
//   - any other insert: decode, then a compare for each stored entry with a
//     lower score, then a compare that places it or, if every entry is
//     lower, a head write, then finish, since the insert walks from the tail
//     one entry per cycle through the memory port.
// The result is loaded into the output register in the finish state.
// If the previous result is still waiting there, the request holds until that
// result is taken. A pop on an empty queue or an insert into a full queue is
// refused with the error flag set. The next request is accepted while the
// previous result waits in the output register. Tags keep their low TAG_BITS
// bits.
module stable_max_priority_queue #(
  parameter int DEPTH    = smpq_pkg::DEPTH_DEF,
  parameter int TAG_BITS = smpq_pkg::TAG_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [smpq_pkg::IN_DATA_W-1:0]  in_tdata,   // score[31:0], tag[47:32]
  input  logic                            in_tuser,   // req_type
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [smpq_pkg::OUT_DATA_W-1:0] out_tdata,  // out_score[31:0], out_tag[47:32],
                                                      // occupancy[54:48], zero[55]
  output logic [1:0]                      out_tuser   // out_valid[0], error[1]
);
  import smpq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  smpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  smpq_dp #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req_type (in_tuser),
    .in_score    (in_tdata[SCORE_W-1:0]),
    .in_tag      (in_tdata[SCORE_W+TAG_W-1:SCORE_W]),
    .cmd         (cmd),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

FILE: sim/stable_max_priority_queue_test.sv
// Self-checking testbench for stable_max_priority_queue: drives insert and pop
// requests, predicts each result with a sorted-list model and compares fields.
// Depends on smpq_pkg and the stable_max_priority_queue RTL.
`timescale 1ns / 1ps

module stable_max_priority_queue_test;

  localparam int DEPTH     = smpq_pkg::DEPTH_DEF;
  localparam int LIMIT     = 1000000;
  localparam bit REQ_INS   = 1'b0;
  localparam bit REQ_POP   = 1'b1;

  typedef struct packed {
    logic        req;
    logic [15:0] tag;
    logic [31:0] score;
  } request_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] score;
    logic [15:0] tag;
    logic        err;
    logic [6:0]  occ;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [smpq_pkg::IN_DATA_W-1:0] in_tdata = '0;  // score[31:0], tag[47:32]
  logic in_tuser = 1'b0;                          // req_type
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [smpq_pkg::OUT_DATA_W-1:0] out_tdata;     // score, tag, occupancy, zero
  logic [1:0] out_tuser;                          // out_valid, error

  request_t pending_reqs[$];
  result_t  expected_results[$];
  logic signed [31:0] q_score[$];
  logic [15:0]        q_tag[$];
  int  failures = 0;
  int  cycles = 0;
  bit  calm = 1'b0;

  stable_max_priority_queue dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Sorted-list prediction of one accepted request
  function automatic result_t predict_queue(request_t r);
    result_t res;
    int pos;
    res = '0;
    if (r.req == REQ_POP) begin
      if (q_score.size() == 0) begin
        res.err = 1'b1;
      end else begin
        res.valid = 1'b1;
        res.score = q_score.pop_front();
        res.tag = q_tag.pop_front();
      end
    end else if (q_score.size() >= DEPTH) begin
      res.err = 1'b1;
    end else begin
      pos = 0;
      while (pos < q_score.size() && q_score[pos] >= $signed(r.score)) pos++;
      q_score.insert(pos, r.score);
      q_tag.insert(pos, r.tag);
    end
    res.occ = 7'(q_score.size());
    return res;
  endfunction

  // Driver: retire the accepted request, then present the next one or idle
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (in_tvalid) begin
          expected_results.push_back(predict_queue(pending_reqs.pop_front()));
        end
        if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {pending_reqs[0].tag, pending_reqs[0].score};
          in_tuser  <= pending_reqs[0].req;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    cycles <= cycles + 1;
    out_tready <= calm || $urandom_range(99) >= 10;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result");
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (out_tuser[0] !== want.valid) begin
          $error("out_valid exp %0d got %0d", want.valid, out_tuser[0]); failures++;
        end
        if (out_tdata[31:0] !== want.score) begin
          $error("out_score exp %0d got %0d", $signed(want.score),
                 $signed(out_tdata[31:0])); failures++;
        end
        if (out_tdata[47:32] !== want.tag) begin
          $error("out_tag exp %0h got %0h", want.tag, out_tdata[47:32]); failures++;
        end
        if (out_tuser[1] !== want.err) begin
          $error("error exp %0d got %0d", want.err, out_tuser[1]); failures++;
        end
        if (out_tdata[54:48] !== want.occ) begin
          $error("occupancy exp %0d got %0d", want.occ, out_tdata[54:48]); failures++;
        end
      end
    end
  end

  function automatic request_t make_req(bit req, logic [31:0] score, logic [15:0] tag);
    request_t r;
    r.req = req;
    r.score = score;
    r.tag = tag;
    return r;
  endfunction

  function automatic logic [31:0] rand_score();
    case ($urandom_range(3))
      0: return 32'($urandom_range(7)) - 32'd4;
      1: return ($urandom_range(1) ? 32'h8000_0000 : 32'h7fff_fffc) +
                32'($urandom_range(3));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    // Directed: empty pop, extremes, ties, then fill past full and drain
    pending_reqs.push_back(make_req(REQ_POP, 32'h1234_5678, 16'hffff));
    pending_reqs.push_back(make_req(REQ_INS, 32'h8000_0000, 16'h0000));
    pending_reqs.push_back(make_req(REQ_INS, 32'h7fff_ffff, 16'hffff));
    pending_reqs.push_back(make_req(REQ_INS, 32'h0000_0005, 16'h0001));
    pending_reqs.push_back(make_req(REQ_INS, 32'h0000_0005, 16'h0002));
    pending_reqs.push_back(make_req(REQ_INS, 32'hffff_ffff, 16'h0003));
    for (int i = 0; i < 7; i++) pending_reqs.push_back(make_req(REQ_POP, '0, '0));
    for (int i = 0; i < DEPTH + 3; i++) begin
      pending_reqs.push_back(make_req(REQ_INS, 32'($urandom_range(3)), 16'($urandom())));
    end
    for (int i = 0; i < DEPTH + 1; i++) pending_reqs.push_back(make_req(REQ_POP, '0, '0));
    // Random: bursts biased toward insert or pop to sweep occupancy
    for (int b = 0; b < 22; b++) begin
      int bias;
      bias = $urandom_range(20, 80);
      for (int i = 0; i < 50; i++) begin
        pending_reqs.push_back(make_req($urandom_range(99) < bias, rand_score(),
                                        16'($urandom())));
      end
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    fork
      begin
        repeat (1500) @(posedge clk);
        calm = 1'b1;
        repeat (800) @(posedge clk);
        calm = 1'b0;
      end
    join_none
    while (pending_reqs.size() > 0 || in_tvalid || expected_results.size() > 0) begin
      @(posedge clk);
      if (cycles > LIMIT) begin
        $display("stable_max_priority_queue: mismatch");
        $finish;
      end
    end
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("stable_max_priority_queue: match");
    end else begin
      $display("stable_max_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/smpq_pkg.sv
rtl/smpq_ctrl.sv
rtl/smpq_dp.sv
rtl/stable_max_priority_queue.sv
sim/stable_max_priority_queue_test.sv
